FILE: sv/biquad_iir_filter_defines.svh
// assertion macros shared by the biquad filter rtl
// no dependencies; included by the modules that carry assertions
`ifndef BIQUAD_IIR_FILTER_DEFINES_SVH
`define BIQUAD_IIR_FILTER_DEFINES_SVH

`ifndef SYNTHESIS
// property checked on the rising clock edge, switched off while reset is low
`define BQF_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: assertion failed");
// property checked on the rising clock edge, also during reset
`define BQF_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");
`else
`define BQF_ASSERT(lbl, clk, rstn, prop)
`define BQF_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

FILE: sv/bqf_pkg.sv
// shared types and constants of the biquad filter
// no dependencies
`default_nettype none

package bqf_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int COEF_FRAC  = 15;
  localparam int COEF_W     = 18;
  localparam int INIT_W     = 32;
  localparam int STATE_W    = 40;
  localparam int PROD_W     = COEF_W + SAMPLE_W;
  localparam int ACC_W      = STATE_W + 2;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  // 1.0 in the coefficient format
  localparam logic signed [COEF_W-1:0] COEF_ONE =
    {{(COEF_W-COEF_FRAC-1){1'b0}}, 1'b1, {COEF_FRAC{1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B0,
    REG_B1,
    REG_B2,
    REG_A1,
    REG_A2,
    REG_INIT1,
    REG_INIT2
  } reg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_B0,
    S_Y,
    S_N1A,
    S_N1B,
    S_N2A,
    S_N2B,
    S_PUSH
  } state_e;

  typedef enum logic [2:0] {
    MUL_B0,
    MUL_B1,
    MUL_B2,
    MUL_A1,
    MUL_A2
  } mul_sel_e;

  typedef enum logic [2:0] {
    ACC_IDLE,
    ACC_Y,
    ACC_LOAD_D2,
    ACC_WR_D1,
    ACC_LOAD,
    ACC_WR_D2
  } acc_op_e;

  typedef struct packed {
    logic     load;
    logic     push;
    mul_sel_e mul_sel;
    acc_op_e  acc_op;
  } cmd_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
    logic signed [INIT_W-1:0] init1;
    logic signed [INIT_W-1:0] init2;
  } cfg_t;

endpackage

`default_nettype wire

FILE: sv/biquad_iir_filter.sv
// top level of the second-order iir filter (transposed direct form ii)
// depends on bqf_pkg, bqf_cfg, bqf_ctrl, bqf_datapath
`default_nettype none

// biquad filter, one signed 16-bit sample in, one rounded and saturated sample
// out. coefficients b0 b1 b2 a1 a2 are signed q3.15 already divided by a0 and
// are written through the register port (index 0..6: b0, b1, b2, a1, a2,
// first initial state, second initial state); write them only while the
// filter is idle. a request with start_block_i set first loads both 40-bit
// delay states from the initial-state registers. one 18x16 multiplier is
// shared by the five products of a sample, so a request passes through the
// accept state, six multiply/accumulate steps and the hand-off before its
// result enters the output register. the next request is taken right after
// that hand-off while the previous result still waits in the output
// register; a stalled output only holds the sequencer once a second result
// is ready. saturated_o marks a clipped output sample; the delay states clip
// silently to 40 bits. no clearing pass after reset.

module biquad_iir_filter (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // register port
  input  wire logic                                cfg_we_i,
  input  wire logic [bqf_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [bqf_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  // input requests
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic signed [bqf_pkg::SAMPLE_W-1:0] sample_in_i,
  input  wire logic                                start_block_i,
  // output requests
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic signed [bqf_pkg::SAMPLE_W-1:0]      sample_out_o,
  output logic                                     saturated_o
);

  bqf_pkg::cfg_t cfg;
  bqf_pkg::cmd_t cmd;

  // coefficient and initial-state registers
  bqf_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // sequencer: handshakes and multiply/accumulate schedule
  bqf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // shared multiplier, accumulator, delay states and output register
  bqf_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_i         (cfg),
    .sample_in_i   (sample_in_i),
    .start_block_i (start_block_i),
    .sample_out_o  (sample_out_o),
    .saturated_o   (saturated_o)
  );

endmodule

`default_nettype wire

FILE: sv/bqf_cfg.sv
// coefficient and initial-state register file of the biquad filter
// depends on bqf_pkg
`default_nettype none

module bqf_cfg (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [bqf_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [bqf_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  output bqf_pkg::cfg_t                         cfg_o
);

  bqf_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (bqf_pkg::reg_idx_e'(cfg_idx_i))
        bqf_pkg::REG_B0:    cfg_d.b0    = cfg_wdata_i[bqf_pkg::COEF_W-1:0];
        bqf_pkg::REG_B1:    cfg_d.b1    = cfg_wdata_i[bqf_pkg::COEF_W-1:0];
        bqf_pkg::REG_B2:    cfg_d.b2    = cfg_wdata_i[bqf_pkg::COEF_W-1:0];
        bqf_pkg::REG_A1:    cfg_d.a1    = cfg_wdata_i[bqf_pkg::COEF_W-1:0];
        bqf_pkg::REG_A2:    cfg_d.a2    = cfg_wdata_i[bqf_pkg::COEF_W-1:0];
        bqf_pkg::REG_INIT1: cfg_d.init1 = cfg_wdata_i[bqf_pkg::INIT_W-1:0];
        bqf_pkg::REG_INIT2: cfg_d.init2 = cfg_wdata_i[bqf_pkg::INIT_W-1:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.b0    <= bqf_pkg::COEF_ONE;
      cfg_q.b1    <= '0;
      cfg_q.b2    <= '0;
      cfg_q.a1    <= '0;
      cfg_q.a2    <= '0;
      cfg_q.init1 <= '0;
      cfg_q.init2 <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: sv/bqf_datapath.sv
// biquad datapath: shared multiplier, accumulator, delay states, output register
// depends on bqf_pkg
`default_nettype none

module bqf_datapath (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire bqf_pkg::cmd_t                       cmd_i,
  input  wire bqf_pkg::cfg_t                       cfg_i,
  input  wire logic signed [bqf_pkg::SAMPLE_W-1:0] sample_in_i,
  input  wire logic                                start_block_i,
  output logic signed [bqf_pkg::SAMPLE_W-1:0]      sample_out_o,
  output logic                                     saturated_o
);

  localparam int YF_W = bqf_pkg::ACC_W - bqf_pkg::COEF_FRAC;
  localparam int SW   = bqf_pkg::SAMPLE_W;
  localparam int STW  = bqf_pkg::STATE_W;
  localparam int AW   = bqf_pkg::ACC_W;
  localparam int PW   = bqf_pkg::PROD_W;
  localparam int IW   = bqf_pkg::INIT_W;

  localparam logic signed [AW-1:0] RND_HALF =
    {{(AW-bqf_pkg::COEF_FRAC){1'b0}}, 1'b1, {(bqf_pkg::COEF_FRAC-1){1'b0}}};
  localparam logic signed [YF_W-1:0] Y_MAX = {{(YF_W-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [YF_W-1:0] Y_MIN = {{(YF_W-SW+1){1'b1}}, {(SW-1){1'b0}}};
  localparam logic signed [AW-1:0]   D_MAX = {{(AW-STW+1){1'b0}}, {(STW-1){1'b1}}};
  localparam logic signed [AW-1:0]   D_MIN = {{(AW-STW+1){1'b1}}, {(STW-1){1'b0}}};

  logic signed [SW-1:0]  x_q;
  logic signed [SW-1:0]  y_q, y_d;
  logic                  sat_q, sat_d;
  logic signed [STW-1:0] d1_q, d1_d;
  logic signed [STW-1:0] d2_q, d2_d;
  logic signed [AW-1:0]  acc_q, acc_d;
  logic signed [PW-1:0]  prod_q, prod_d;

  logic signed [bqf_pkg::COEF_W-1:0] mul_a;
  logic signed [SW-1:0]              mul_b;
  logic signed [AW-1:0]              prod_ext, d1_ext, d2_ext, rnd, diff;
  logic signed [YF_W-1:0]            y_full;
  logic signed [STW-1:0]             diff_clip;

  // shared multiplier operand select
  always_comb begin
    mul_a = cfg_i.b0;
    mul_b = x_q;
    case (cmd_i.mul_sel)
      bqf_pkg::MUL_B0: begin mul_a = cfg_i.b0; mul_b = x_q; end
      bqf_pkg::MUL_B1: begin mul_a = cfg_i.b1; mul_b = x_q; end
      bqf_pkg::MUL_B2: begin mul_a = cfg_i.b2; mul_b = x_q; end
      bqf_pkg::MUL_A1: begin mul_a = cfg_i.a1; mul_b = y_q; end
      bqf_pkg::MUL_A2: begin mul_a = cfg_i.a2; mul_b = y_q; end
      default:         begin mul_a = cfg_i.b0; mul_b = x_q; end
    endcase
  end

  assign prod_d   = mul_a * mul_b;
  assign prod_ext = {{(AW-PW){prod_q[PW-1]}}, prod_q};
  assign d1_ext   = {{(AW-STW){d1_q[STW-1]}}, d1_q};
  assign d2_ext   = {{(AW-STW){d2_q[STW-1]}}, d2_q};

  // output sample: round half up, then clip to the sample range
  assign rnd    = prod_ext + d1_ext + RND_HALF;
  assign y_full = rnd[AW-1:bqf_pkg::COEF_FRAC];

  // state update: clip to the state range
  assign diff = acc_q - prod_ext;
  always_comb begin
    if (diff > D_MAX) begin
      diff_clip = D_MAX[STW-1:0];
    end else if (diff < D_MIN) begin
      diff_clip = D_MIN[STW-1:0];
    end else begin
      diff_clip = diff[STW-1:0];
    end
  end

  always_comb begin
    y_d   = y_q;
    sat_d = sat_q;
    acc_d = acc_q;
    d1_d  = d1_q;
    d2_d  = d2_q;
    if (cmd_i.load && start_block_i) begin
      d1_d = {{(STW-IW){cfg_i.init1[IW-1]}}, cfg_i.init1};
      d2_d = {{(STW-IW){cfg_i.init2[IW-1]}}, cfg_i.init2};
    end
    case (cmd_i.acc_op)
      bqf_pkg::ACC_IDLE: ;
      bqf_pkg::ACC_Y: begin
        if (y_full > Y_MAX) begin
          y_d   = Y_MAX[SW-1:0];
          sat_d = 1'b1;
        end else if (y_full < Y_MIN) begin
          y_d   = Y_MIN[SW-1:0];
          sat_d = 1'b1;
        end else begin
          y_d   = y_full[SW-1:0];
          sat_d = 1'b0;
        end
      end
      bqf_pkg::ACC_LOAD_D2: acc_d = prod_ext + d2_ext;
      bqf_pkg::ACC_WR_D1:   d1_d  = diff_clip;
      bqf_pkg::ACC_LOAD:    acc_d = prod_ext;
      bqf_pkg::ACC_WR_D2:   d2_d  = diff_clip;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d1_q <= '0;
      d2_q <= '0;
    end else begin
      d1_q <= d1_d;
      d2_q <= d2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q <= sample_in_i;
    end
    prod_q <= prod_d;
    acc_q  <= acc_d;
    y_q    <= y_d;
    sat_q  <= sat_d;
    if (cmd_i.push) begin
      sample_out_o <= y_q;
      saturated_o  <= sat_q;
    end
  end

endmodule

`default_nettype wire

FILE: sv/bqf_ctrl.sv
// biquad sequencer: steps the shared multiplier and owns both handshakes
// depends on bqf_pkg and biquad_iir_filter_defines.svh
`default_nettype none
`include "biquad_iir_filter_defines.svh"

module bqf_ctrl (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output bqf_pkg::cmd_t cmd_o
);

  bqf_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            accept;
  logic            slot_free;

  assign in_stall_o  = (state_q != bqf_pkg::S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign slot_free   = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bqf_pkg::S_IDLE: if (accept) state_d = bqf_pkg::S_B0;
      bqf_pkg::S_B0:   state_d = bqf_pkg::S_Y;
      bqf_pkg::S_Y:    state_d = bqf_pkg::S_N1A;
      bqf_pkg::S_N1A:  state_d = bqf_pkg::S_N1B;
      bqf_pkg::S_N1B:  state_d = bqf_pkg::S_N2A;
      bqf_pkg::S_N2A:  state_d = bqf_pkg::S_N2B;
      bqf_pkg::S_N2B:  state_d = bqf_pkg::S_PUSH;
      bqf_pkg::S_PUSH: if (slot_free) state_d = bqf_pkg::S_IDLE;
      default:         state_d = bqf_pkg::S_IDLE;
    endcase
  end

  // commands; s_b0 to s_n2a each issue a product, s_y to s_n2b each consume the previous one
  always_comb begin
    cmd_o.load    = 1'b0;
    cmd_o.push    = 1'b0;
    cmd_o.mul_sel = bqf_pkg::MUL_B0;
    cmd_o.acc_op  = bqf_pkg::ACC_IDLE;
    case (state_q)
      bqf_pkg::S_IDLE: cmd_o.load = accept;
      bqf_pkg::S_B0:   cmd_o.mul_sel = bqf_pkg::MUL_B0;
      bqf_pkg::S_Y: begin
        cmd_o.mul_sel = bqf_pkg::MUL_B1;
        cmd_o.acc_op  = bqf_pkg::ACC_Y;
      end
      bqf_pkg::S_N1A: begin
        cmd_o.mul_sel = bqf_pkg::MUL_A1;
        cmd_o.acc_op  = bqf_pkg::ACC_LOAD_D2;
      end
      bqf_pkg::S_N1B: begin
        cmd_o.mul_sel = bqf_pkg::MUL_B2;
        cmd_o.acc_op  = bqf_pkg::ACC_WR_D1;
      end
      bqf_pkg::S_N2A: begin
        cmd_o.mul_sel = bqf_pkg::MUL_A2;
        cmd_o.acc_op  = bqf_pkg::ACC_LOAD;
      end
      bqf_pkg::S_N2B:  cmd_o.acc_op = bqf_pkg::ACC_WR_D2;
      bqf_pkg::S_PUSH: cmd_o.push = slot_free;
      default: ;
    endcase
  end

  assign out_valid_d = cmd_o.push || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bqf_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  `BQF_ASSERT(a_push_no_overwrite, clk_i, rst_ni, cmd_o.push |-> slot_free)
  `BQF_ASSERT(a_valid_from_push, clk_i, rst_ni,
              $rose(out_valid_q) |-> $past(state_q) == bqf_pkg::S_PUSH)
  `BQF_ASSERT(a_done_has_result, clk_i, rst_ni,
              (state_q == bqf_pkg::S_PUSH) ##1 (state_q == bqf_pkg::S_IDLE) |-> out_valid_q)
  `BQF_ASSERT(a_accept_starts, clk_i, rst_ni, accept |=> state_q == bqf_pkg::S_B0)

endmodule

`default_nettype wire

FILE: verif/tb_biquad_iir_filter.sv
// self-checking testbench for the biquad iir filter: directed and random sample requests,
// a cycle-free prediction of every output sample and a field-by-field check of each one
// depends on bqf_pkg and biquad_iir_filter
`default_nettype none

module tb_biquad_iir_filter;
  import bqf_pkg::*;

  // register 7 does not exist, writes to it must leave the filter untouched
  localparam int NUM_REGS = int'(REG_INIT2) + 1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(NUM_REGS);

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic [CFG_DATA_W-1:0] COEF_MAX = (1 << (COEF_W - 1)) - 1;
  localparam logic [CFG_DATA_W-1:0] COEF_MIN = -(1 << (COEF_W - 1));
  localparam logic [CFG_DATA_W-1:0] COEF_HALF = 1 << (COEF_FRAC - 1);
  localparam logic [CFG_DATA_W-1:0] INIT_MAX = {1'b0, {(INIT_W-1){1'b1}}};
  localparam logic [CFG_DATA_W-1:0] INIT_MIN = {1'b1, {(INIT_W-1){1'b0}}};

  localparam int RANDOM_PHASES   = 12;
  localparam int ITEMS_PER_PHASE = 57;
  localparam int MAX_IDLE        = 5;
  localparam int LONG_HOLD       = 120;  // receiver hold-off that backs the filter up
  localparam int QUIET_LIMIT     = 1000; // cycles with no handshake or register write before giving up
  localparam int DRAIN_CYCLES    = 16;   // wait for stray output requests after the last result

  typedef enum int unsigned {
    KIND_MILD,
    KIND_FULL,
    KIND_EDGE
  } phase_kind_e;

  // one input request as queued for the driver, with the pause that follows it
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       start;
    logic [2:0]                 gap;
  } sample_req_t;

  // one predicted output request
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       clipped;
  } filtered_t;

  logic                       clk_i         = 1'b0;
  logic                       rst_ni        = 1'b0;
  logic                       cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0]      cfg_wdata_i   = '0;
  logic                       in_valid_i    = 1'b0;
  logic                       in_stall_o;
  logic signed [SAMPLE_W-1:0] sample_in_i   = '0;
  logic                       start_block_i = 1'b0;
  logic                       out_valid_o;
  logic                       out_stall_i   = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_out_o;
  logic                       saturated_o;

  biquad_iir_filter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .sample_in_i   (sample_in_i),
    .start_block_i (start_block_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .sample_out_o  (sample_out_o),
    .saturated_o   (saturated_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // shadow of the register file and of the two delay states, as the filter should hold them
  logic [CFG_DATA_W-1:0] reg_shadow [NUM_REGS];
  longint                delay_first  = 0;
  longint                delay_second = 0;

  sample_req_t pending_samples[$];
  filtered_t   expected_outputs[$];

  int unsigned gap_max   = 0;
  int unsigned stall_max = 0;
  int          err_count = 0;
  int          quiet_cycles;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // coefficient register as a signed q3.15 value
  function automatic longint coef_value(input reg_idx_e idx);
    logic signed [COEF_W-1:0] c;
    c = reg_shadow[idx][COEF_W-1:0];
    return c;
  endfunction

  function automatic longint clip_signed(input longint v, input int w, inout bit hit);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      hit = 1'b1;
      return hi;
    end
    if (v < lo) begin
      hit = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // one step of the transposed direct form ii, queues the output sample it gives
  function automatic void run_biquad(input logic signed [SAMPLE_W-1:0] x_in,
                                     input logic start);
    logic signed [INIT_W-1:0] init_val;
    longint    x;
    longint    acc;
    longint    y;
    longint    n1;
    longint    n2;
    bit        out_hit;
    bit        state_hit;
    filtered_t res;
    out_hit   = 1'b0;
    state_hit = 1'b0;
    x = x_in;
    // a block start reloads both delay states before the sample is used
    if (start) begin
      init_val     = reg_shadow[REG_INIT1][INIT_W-1:0];
      delay_first  = init_val;
      init_val     = reg_shadow[REG_INIT2][INIT_W-1:0];
      delay_second = init_val;
    end
    acc = coef_value(REG_B0) * x + delay_first;
    // round half up: arithmetic shift of a signed value is a floor
    y = (acc + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
    y = clip_signed(y, SAMPLE_W, out_hit);
    // feedback uses the rounded and clipped output
    n1 = coef_value(REG_B1) * x - coef_value(REG_A1) * y + delay_second;
    n2 = coef_value(REG_B2) * x - coef_value(REG_A2) * y;
    // state clipping is silent, it never sets the output flag
    delay_first  = clip_signed(n1, STATE_W, state_hit);
    delay_second = clip_signed(n2, STATE_W, state_hit);
    res.sample  = y[SAMPLE_W-1:0];
    res.clipped = out_hit;
    expected_outputs.insert(expected_outputs.size(), res);
  endfunction

  // ---------------------------------------------------------------------------
  // driver: offers queued requests, predicts each one as it is accepted
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : driver
    sample_req_t cur;
    logic        next_valid;
    int unsigned gap_left;
    if (!rst_ni) begin
      in_valid_i    <= 1'b0;
      sample_in_i   <= '0;
      start_block_i <= 1'b0;
      gap_left = 0;
    end else begin
      next_valid = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        run_biquad(sample_in_i, start_block_i);
        next_valid = 1'b0;
      end
      // after a request goes through, wait its pause, then offer the next one;
      // with no pause valid simply stays high
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_samples.size() > 0) begin
          cur = pending_samples.pop_front();
          sample_in_i   <= cur.sample;
          start_block_i <= cur.start;
          gap_left   = cur.gap;
          next_valid = 1'b1;
        end
      end
      in_valid_i <= next_valid;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks output requests against the oldest prediction, drives stall
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    filtered_t   want;
    int unsigned stall_left;
    int unsigned results_seen;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left   = 0;
      results_seen = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_outputs.size() == 0) begin
          $error("output request with no sample outstanding: sample_out %0d", sample_out_o);
          err_count++;
        end else begin
          want = expected_outputs.pop_front();
          if (sample_out_o !== want.sample) begin
            $error("sample_out: expected %0d, got %0d", want.sample, sample_out_o);
            err_count++;
          end
          if (saturated_o !== want.clipped) begin
            $error("saturated: expected %0d, got %0d", want.clipped, saturated_o);
            err_count++;
          end
        end
        results_seen++;
        stall_left = $urandom_range(0, stall_max);
        // now and then hold off for a long stretch so the filter backs up and
        // stalls the sender, who keeps offering requests meanwhile
        if (results_seen % 250 == 100) begin
          stall_left = LONG_HOLD;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: no handshake for too long means the filter hung
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // write enable is left high, the caller lowers it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    if (idx <= REG_A2) begin
      reg_shadow[idx] = {{(CFG_DATA_W-COEF_W){1'b0}}, data[COEF_W-1:0]};
    end else if (idx < NUM_REGS) begin
      reg_shadow[idx] = data;
    end
  endtask

  // full register set, plus a write to the unused index that must change nothing
  task automatic load_filter(input logic [CFG_DATA_W-1:0] b0, b1, b2, a1, a2, init1, init2);
    write_reg(REG_B0, b0);
    write_reg(REG_B1, b1);
    write_reg(REG_B2, b2);
    write_reg(REG_A1, a1);
    write_reg(REG_A2, a2);
    write_reg(REG_INIT1, init1);
    write_reg(REG_INIT2, init2);
    write_reg(REG_SPARE, $urandom());
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic queue_sample(input logic signed [SAMPLE_W-1:0] sample, input logic start);
    sample_req_t req;
    req.sample = sample;
    req.start  = start;
    req.gap    = 3'($urandom_range(0, gap_max));
    pending_samples.insert(pending_samples.size(), req);
  endtask

  // filter idle: nothing queued, nothing offered, nothing outstanding
  task automatic wait_idle();
    while (pending_samples.size() != 0 || in_valid_i || expected_outputs.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  function automatic logic signed [SAMPLE_W-1:0] sample_pick();
    case ($urandom_range(0, 7))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return '0;
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  // upper data bits are random in the full case, the filter must drop them
  function automatic logic [CFG_DATA_W-1:0] coef_pick(input phase_kind_e kind);
    case (kind)
      KIND_MILD: return $urandom_range(0, 2 * COEF_HALF) - COEF_HALF;
      KIND_FULL: return $urandom();
      default: begin
        case ($urandom_range(0, 2))
          0: return COEF_MAX;
          1: return COEF_MIN;
          default: return '0;
        endcase
      end
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] init_pick(input phase_kind_e kind);
    case (kind)
      KIND_MILD: return $urandom_range(0, 1 << 20) - (1 << 19);
      KIND_FULL: return $urandom();
      default: begin
        case ($urandom_range(0, 2))
          0: return INIT_MAX;
          1: return INIT_MIN;
          default: return '0;
        endcase
      end
    endcase
  endfunction

  // one setting of the filter, then blocks of samples each opened by a start
  task automatic random_phase(input phase_kind_e kind);
    int left;
    int run;
    load_filter(coef_pick(kind), coef_pick(kind), coef_pick(kind), coef_pick(kind),
                coef_pick(kind), init_pick(kind), init_pick(kind));
    left = ITEMS_PER_PHASE;
    while (left > 0) begin
      run = $urandom_range(1, 30);
      for (int k = 0; k < run && left > 0; k++) begin
        // a stray start inside a block restarts it from the initial states
        queue_sample(sample_pick(), k == 0 || $urandom_range(0, 15) == 0);
        left--;
      end
    end
    wait_idle();
  endtask

  initial begin : stimulus
    reg_shadow[REG_B0]    = CFG_DATA_W'(COEF_ONE);
    reg_shadow[REG_B1]    = '0;
    reg_shadow[REG_B2]    = '0;
    reg_shadow[REG_A1]    = '0;
    reg_shadow[REG_A2]    = '0;
    reg_shadow[REG_INIT1] = '0;
    reg_shadow[REG_INIT2] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset coefficients: b0 is one, everything else zero, so samples pass through
    queue_sample(SAMPLE_MAX, 1'b1);
    queue_sample(SAMPLE_MIN, 1'b0);
    queue_sample('0, 1'b0);
    queue_sample(1, 1'b0);
    queue_sample(-1, 1'b0);
    wait_idle();

    // gain of one half: odd samples land exactly on a half, which rounds upward
    load_filter(COEF_HALF, '0, '0, '0, '0, '0, '0);
    queue_sample(1, 1'b1);
    queue_sample(-1, 1'b0);
    queue_sample(3, 1'b0);
    queue_sample(-3, 1'b0);
    wait_idle();

    // largest feedforward, most negative feedback, extreme initial states:
    // output clips both ways
    load_filter(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN, INIT_MAX, INIT_MIN);
    queue_sample(SAMPLE_MAX, 1'b1);
    queue_sample(SAMPLE_MIN, 1'b0);
    queue_sample(SAMPLE_MAX, 1'b0);
    queue_sample(SAMPLE_MIN, 1'b0);
    queue_sample('0, 1'b1);
    queue_sample('0, 1'b0);
    wait_idle();

    // every coefficient at its minimum, initial states swapped
    load_filter(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, INIT_MIN, INIT_MAX);
    queue_sample(SAMPLE_MAX, 1'b1);
    queue_sample(SAMPLE_MIN, 1'b0);
    queue_sample('0, 1'b0);
    queue_sample(1, 1'b0);
    queue_sample(-1, 1'b0);
    wait_idle();

    // random settings; every fourth phase runs with no idling on either side
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p % 4 == 3) begin
        gap_max   = 0;
        stall_max = 0;
      end else begin
        gap_max   = MAX_IDLE;
        stall_max = MAX_IDLE;
      end
      random_phase(phase_kind_e'(p % 3));
    end

    // let any stray output request show up before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
